### sv/rccd_pkg.sv
// ----------------------------------------------------------------------------
// rccd_pkg
// Shared types and constants of the RGB color change detector.
// ----------------------------------------------------------------------------
package rccd_pkg;

   localparam int SampleWidth   = 16;
   localparam int NumChannels   = 3;
   localparam int HistoryDepth  = 4;
   localparam int WeightWidth   = 4;
   localparam int ConfWidth     = 6;
   localparam int CountWidth    = 8;
   localparam int CsrAddrWidth  = 5;
   localparam int CsrDataWidth  = 32;
   localparam int ReqDataWidth  = NumChannels * SampleWidth;
   localparam int RspDataWidth  = 16;

   // channel order inside the request word and the changed vector
   localparam int ChanRed   = 0;
   localparam int ChanGreen = 1;
   localparam int ChanBlue  = 2;

   typedef enum logic [2:0] {
      RegThreshold = 3'd0,
      RegConfLimit = 3'd1,
      RegRedWeight = 3'd2,
      RegGrnWeight = 3'd3,
      RegBluWeight = 3'd4,
      RegFinish    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [SampleWidth-1:0] threshold;
      logic [ConfWidth-1:0]   score_limit;
      logic [WeightWidth-1:0] red_weight;
      logic [WeightWidth-1:0] green_weight;
      logic [WeightWidth-1:0] blue_weight;
      logic [CountWidth-1:0]  finish_count;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      threshold:    SampleWidth'(512),
      score_limit:  ConfWidth'(2),
      red_weight:   WeightWidth'(1),
      green_weight: WeightWidth'(1),
      blue_weight:  WeightWidth'(1),
      finish_count: CountWidth'(3)
   };

   // result word, reaction_active in bit 0
   typedef struct packed {
      logic [ConfWidth-1:0]  confidence;
      logic                  finished;
      logic [CountWidth-1:0] change_count;
      logic                  reaction_active;
   } rsp_word_type;

   typedef struct packed {
      logic done;
      logic warm;
   } core_status_type;

endpackage

### sv/rccd_csr.sv
// ----------------------------------------------------------------------------
// rccd_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module rccd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rccd_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [rccd_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [rccd_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                                csr_pready,
   output rccd_pkg::cfg_type                   cfg
);
   import rccd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type reg_idx;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            RegThreshold: cfg_in.threshold    = csr_pwdata[SampleWidth-1:0];
            RegConfLimit: cfg_in.score_limit  = csr_pwdata[ConfWidth-1:0];
            RegRedWeight: cfg_in.red_weight   = csr_pwdata[WeightWidth-1:0];
            RegGrnWeight: cfg_in.green_weight = csr_pwdata[WeightWidth-1:0];
            RegBluWeight: cfg_in.blue_weight  = csr_pwdata[WeightWidth-1:0];
            RegFinish:    cfg_in.finish_count = csr_pwdata[CountWidth-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         RegThreshold: csr_prdata = CsrDataWidth'(cfg_ff.threshold);
         RegConfLimit: csr_prdata = CsrDataWidth'(cfg_ff.score_limit);
         RegRedWeight: csr_prdata = CsrDataWidth'(cfg_ff.red_weight);
         RegGrnWeight: csr_prdata = CsrDataWidth'(cfg_ff.green_weight);
         RegBluWeight: csr_prdata = CsrDataWidth'(cfg_ff.blue_weight);
         RegFinish:    csr_prdata = CsrDataWidth'(cfg_ff.finish_count);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/rccd_channel.sv
// ----------------------------------------------------------------------------
// rccd_channel
// One color channel: latched sample, sample history and change compare.
// ----------------------------------------------------------------------------
module rccd_channel #(
   parameter int HISTORY_DEPTH = rccd_pkg::HistoryDepth
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               shift_en,
   input  logic                               sample_valid,
   input  logic [rccd_pkg::SampleWidth-1:0]   sample,
   input  logic [rccd_pkg::SampleWidth-1:0]   threshold,
   output logic                               changed
);
   import rccd_pkg::*;

   // the oldest entry is compared with the new sample before a shift drops it
   localparam int HistLen = HISTORY_DEPTH - 1;

   logic [SampleWidth-1:0] latched_ff;
   logic [SampleWidth-1:0] latched_in;
   logic [SampleWidth-1:0] hist_ff [HistLen];
   logic [SampleWidth-1:0] oldest;
   logic [SampleWidth-1:0] diff;

   assign latched_in = sample_valid ? sample : latched_ff;
   assign oldest     = hist_ff[HistLen-1];
   assign diff       = (latched_in > oldest) ? (latched_in - oldest) : (oldest - latched_in);
   assign changed    = diff > threshold;

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff <= '0;
      end else if (shift_en) begin
         latched_ff <= latched_in;
      end
   end

   // history holds written entries only by the time it is compared
   always_ff @(posedge clock) begin
      if (shift_en) begin
         hist_ff[0] <= latched_in;
         for (int i = 1; i < HistLen; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

endmodule

### sv/rccd_core.sv
// ----------------------------------------------------------------------------
// rccd_core
// Confidence score, warm-up, change count and reaction/finish flags.
// ----------------------------------------------------------------------------
module rccd_core #(
   parameter int HISTORY_DEPTH = rccd_pkg::HistoryDepth
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fire,
   input  logic [rccd_pkg::NumChannels-1:0]     changed,
   input  rccd_pkg::cfg_type                    cfg,
   output rccd_pkg::rsp_word_type               result,
   output rccd_pkg::core_status_type            status
);
   import rccd_pkg::*;

   localparam int WarmWidth = $clog2(HISTORY_DEPTH);
   localparam logic [WarmWidth-1:0] WarmSat = WarmWidth'(HISTORY_DEPTH - 1);

   logic [WarmWidth-1:0]  warm_ff, warm_in;
   logic [ConfWidth-1:0]  prev_ff, prev_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  flag_ff, flag_in;
   logic                  done_ff, done_in;
   logic [ConfWidth-1:0]  conf;
   logic [ConfWidth-1:0]  red_part, green_part, blue_part;
   logic                  warm;

   assign warm = (warm_ff == WarmSat);

   assign red_part   = changed[ChanRed]   ? ConfWidth'(cfg.red_weight)   : '0;
   assign green_part = changed[ChanGreen] ? ConfWidth'(cfg.green_weight) : '0;
   assign blue_part  = changed[ChanBlue]  ? ConfWidth'(cfg.blue_weight)  : '0;
   assign conf       = red_part + green_part + blue_part;

   always_comb begin
      warm_in  = warm_ff;
      prev_in  = prev_ff;
      count_in = count_ff;
      flag_in  = flag_ff;
      done_in  = done_ff;
      result.confidence = '0;
      if (!done_ff) begin
         if (!warm) begin
            warm_in = warm_ff + 1'b1;
         end else begin
            result.confidence = conf;
            if (conf > cfg.score_limit) begin
               flag_in  = 1'b0;
               count_in = count_ff + 1'b1;
               done_in  = count_in >= cfg.finish_count;
            end
            // drop rule beats a change in the same word unless done_in is set
            if (!done_in) begin
               if (conf < prev_ff) begin
                  flag_in  = 1'b1;
                  count_in = '0;
               end
               prev_in = conf;
            end
         end
      end
      result.reaction_active = flag_in;
      result.change_count    = count_in;
      result.finished        = done_in;
   end

   assign status.done = done_ff;
   assign status.warm = warm;

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff  <= '0;
         prev_ff  <= '0;
         count_ff <= '0;
         flag_ff  <= 1'b1;
         done_ff  <= 1'b0;
      end else if (fire) begin
         warm_ff  <= warm_in;
         prev_ff  <= prev_in;
         count_ff <= count_in;
         flag_ff  <= flag_in;
         done_ff  <= done_in;
      end
   end

endmodule

### sv/rgb_color_change_detector_unit.sv
// ----------------------------------------------------------------------------
// rgb_color_change_detector_unit
// Watches an RGB sensor stream and flags color changes by weighted channel
// differences against a sample three words back.
// ----------------------------------------------------------------------------
// Use:
//   req_* carries one sensor word: red, green, blue counts in tdata and the
//   sample valid flag in tuser (0 reuses the last latched sample).
//   rsp_* returns exactly one result word per request word, in order:
//   reaction flag, change count, finished flag and this word's confidence.
//   csr_* is an APB-style register port, pready always high, registers at
//   byte address 4*i; write it only while no word is in flight.
// Path: a word accepted into the input register is scored and written to the
//   output register once that register is free; rsp_tvalid then rises.
// Throughput: one word per cycle while rsp_tready is high. The input
//   register feeds one pass of compare and score logic into the output
//   register; state advances as the word moves from one to the other.
// Stall: while rsp_tready is low a full output register holds; an empty
//   input register still takes one more word, then req_tready drops.
// Reset: both registers empty, history warm-up restarts, reaction flag set,
//   count and finished cleared, registers back to their defaults.
// ----------------------------------------------------------------------------
module rgb_color_change_detector_unit #(
   parameter int HISTORY_DEPTH = rccd_pkg::HistoryDepth
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: red [15:0], green [31:16], blue [47:32]
   input  logic [rccd_pkg::ReqDataWidth-1:0]   req_tdata,
   // request: sample_valid [0]
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // result: reaction_active [0], change_count [8:1], finished [9],
   //         confidence [15:10]
   output logic [rccd_pkg::RspDataWidth-1:0]   rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rccd_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [rccd_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [rccd_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import rccd_pkg::*;

   cfg_type                 cfg;
   rsp_word_type            result;
   core_status_type         status;

   logic                    in_valid_ff;
   logic [ReqDataWidth-1:0] in_data_ff;
   logic                    in_user_ff;
   logic                    out_valid_ff;
   rsp_word_type            out_data_ff;

   logic                    out_free;
   logic                    advance;
   logic                    shift_en;
   logic [NumChannels-1:0]  changed;

   // output register is free when empty or being drained this cycle
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   // freeze history once finished
   assign shift_en   = advance && !status.done;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   rccd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   for (genvar c = 0; c < NumChannels; c++) begin : g_chan
      rccd_channel #(
         .HISTORY_DEPTH (HISTORY_DEPTH)
      ) u_channel (
         .clock        (clock),
         .reset        (reset),
         .shift_en     (shift_en),
         .sample_valid (in_user_ff),
         .sample       (in_data_ff[c*SampleWidth +: SampleWidth]),
         .threshold    (cfg.threshold),
         .changed      (changed[c])
      );
   end

   rccd_core #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .changed (changed),
      .cfg     (cfg),
      .result  (result),
      .status  (status)
   );

   // input register: take a word whenever the slot frees up
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_user_ff <= req_tuser;
      end
   end

   // output register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

`ifndef NO_ASSERTIONS
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      status.done |=> status.done)
      else $error("finished state left without reset");

   a_done_frozen: assert property (@(posedge clock) disable iff (reset)
      (advance && status.done) |-> (result.finished && result.confidence == '0))
      else $error("finished block produced a live result");

   a_warm_conf: assert property (@(posedge clock) disable iff (reset)
      (advance && result.confidence != '0) |-> status.warm)
      else $error("nonzero confidence during warm-up");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input register would be overwritten while stalled");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB color change detector unit.
// Streams sensor words with random idling on both sides and predicts every
// result word in lockstep with acceptance. It sweeps several register
// settings and ends by driving the block into its finished state.
// ----------------------------------------------------------------------------
module tb;
   import rccd_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int TrailDepth = HistoryDepth - 1;

   typedef struct packed {
      logic                   valid;
      logic [SampleWidth-1:0] blue;
      logic [SampleWidth-1:0] green;
      logic [SampleWidth-1:0] red;
   } sensor_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic [ReqDataWidth-1:0]   req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [RspDataWidth-1:0]   rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0]   csr_paddr = '0;
   logic [CsrDataWidth-1:0]   csr_pwdata = '0;
   logic [CsrDataWidth-1:0]   csr_prdata;
   logic                      csr_pready;

   // words waiting for the driver, and results the block still owes
   sensor_word_type word_feed [$];
   rsp_word_type    results_due [$];

   // predictor state, a private copy of the block
   cfg_type                cfg_now;
   logic [SampleWidth-1:0] latch_rgb [NumChannels];
   logic [SampleWidth-1:0] trail_rgb [NumChannels][HistoryDepth];
   int                     warm_seen;
   logic [ConfWidth-1:0]   last_score;
   logic [CountWidth-1:0]  run_count;
   logic                   react_on;
   logic                   stopped;

   // stimulus side: latched samples already queued, newest first
   logic [SampleWidth-1:0] gen_trail [NumChannels][TrailDepth];
   logic [SampleWidth-1:0] gen_thr;

   int  words_taken = 0;
   int  results_seen = 0;
   int  mismatches = 0;
   int  settings_used = 0;
   int  cycle_count = 0;
   int  gap_left = 0;
   int  hold_left = 0;
   bit  steady_tail = 1'b0;

   rgb_color_change_detector_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs or drops a result.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
                  results_due.size());
         $display("FAIL rgb_color_change_detector_unit");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic void clear_detector();
      int ch, k;
      cfg_now = CfgReset;
      for (ch = 0; ch < NumChannels; ch++) begin
         latch_rgb[ch] = '0;
         for (k = 0; k < HistoryDepth; k++) trail_rgb[ch][k] = '0;
         for (k = 0; k < TrailDepth; k++) gen_trail[ch][k] = '0;
      end
      warm_seen  = 0;
      last_score = '0;
      run_count  = '0;
      react_on   = 1'b1;
      stopped    = 1'b0;
      gen_thr    = CfgReset.threshold;
   endfunction

   // Advance the detector by one accepted sensor word and return its result.
   function automatic rsp_word_type score_color_word(input sensor_word_type w);
      rsp_word_type           res;
      logic [SampleWidth-1:0] fresh [NumChannels];
      logic [WeightWidth-1:0] wt [NumChannels];
      logic [SampleWidth-1:0] newest, oldest, delta;
      logic [ConfWidth-1:0]   score;
      int                     ch, k;
      score = '0;
      fresh[ChanRed]   = w.red;
      fresh[ChanGreen] = w.green;
      fresh[ChanBlue]  = w.blue;
      wt[ChanRed]      = cfg_now.red_weight;
      wt[ChanGreen]    = cfg_now.green_weight;
      wt[ChanBlue]     = cfg_now.blue_weight;
      if (!stopped) begin
         // an invalid word shifts the held sample in again
         if (w.valid) latch_rgb = fresh;
         for (ch = 0; ch < NumChannels; ch++) begin
            for (k = HistoryDepth - 1; k > 0; k--) trail_rgb[ch][k] = trail_rgb[ch][k-1];
            trail_rgb[ch][0] = latch_rgb[ch];
         end
         if (warm_seen >= HistoryDepth - 1) begin
            for (ch = 0; ch < NumChannels; ch++) begin
               newest = trail_rgb[ch][0];
               oldest = trail_rgb[ch][HistoryDepth-1];
               delta  = (newest > oldest) ? newest - oldest : oldest - newest;
               if (delta > cfg_now.threshold) score = score + ConfWidth'(wt[ch]);
            end
            if (score > cfg_now.score_limit) begin
               react_on  = 1'b0;
               run_count = run_count + 1'b1;
               if (run_count >= cfg_now.finish_count) stopped = 1'b1;
            end
            // the finishing word freezes everything, previous score included
            if (!stopped) begin
               if (score < last_score) begin
                  react_on  = 1'b1;
                  run_count = '0;
               end
               last_score = score;
            end
         end else begin
            warm_seen++;
         end
      end
      res.reaction_active = react_on;
      res.change_count    = run_count;
      res.finished        = stopped;
      res.confidence      = score;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: feed queued words, with random gaps between them
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         // the word on the bus (if any) is taken at this edge
         if (req_tvalid) begin
            results_due.push_back(score_color_word({req_tuser, req_tdata}));
            words_taken++;
         end
         if (gap_left == 0 && !steady_tail && $urandom_range(99) < 6)
            gap_left = $urandom_range(1, 10);
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (word_feed.size() > 0) begin
            sensor_word_type w;
            w = word_feed.pop_front();
            req_tdata  <= {w.blue, w.green, w.red};
            req_tuser  <= w.valid;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: stall in random bursts, check every result word taken
   // ------------------------------------------------------------------------
   task automatic note_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 20)
         $display("%0t ns: result %0d %s: got %0d, expected %0d", $time, results_seen, what,
                  got, want);
   endtask

   task automatic check_result(input rsp_word_type got);
      rsp_word_type want;
      if (results_due.size() == 0) begin
         note_mismatch("arrived with nothing pending", got, 0);
      end else begin
         want = results_due.pop_front();
         if (got.reaction_active !== want.reaction_active)
            note_mismatch("reaction_active", got.reaction_active, want.reaction_active);
         if (got.change_count !== want.change_count)
            note_mismatch("change_count", got.change_count, want.change_count);
         if (got.finished !== want.finished)
            note_mismatch("finished", got.finished, want.finished);
         if (got.confidence !== want.confidence)
            note_mismatch("confidence", got.confidence, want.confidence);
      end
      results_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (hold_left == 0 && !steady_tail && $urandom_range(99) < 6)
            hold_left = $urandom_range(1, 10);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Register access and stimulus helpers
   // ------------------------------------------------------------------------
   // Setup cycle, then access cycle; the register takes the value at the
   // edge that ends the access cycle.
   task automatic write_csr(input reg_index_type idx, input logic [CsrDataWidth-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // only the low bits of each register survive
      case (idx)
         RegThreshold: cfg_now.threshold    = value[SampleWidth-1:0];
         RegConfLimit: cfg_now.score_limit  = value[ConfWidth-1:0];
         RegRedWeight: cfg_now.red_weight   = value[WeightWidth-1:0];
         RegGrnWeight: cfg_now.green_weight = value[WeightWidth-1:0];
         RegBluWeight: cfg_now.blue_weight  = value[WeightWidth-1:0];
         RegFinish:    cfg_now.finish_count = value[CountWidth-1:0];
         default: ;
      endcase
   endtask

   // Wait until every queued word is taken and every result is back, then
   // let the pipeline settle before touching registers.
   task automatic drain();
      do @(negedge clock);
      while (word_feed.size() != 0 || req_tvalid || results_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Queue one word and track which sample the block will hold afterwards.
   task automatic add_word(input logic valid, input logic [SampleWidth-1:0] r, g, b);
      sensor_word_type        w;
      logic [SampleWidth-1:0] held [NumChannels];
      int                     ch, k;
      w.valid = valid;
      w.red   = r;
      w.green = g;
      w.blue  = b;
      word_feed.push_back(w);
      held[ChanRed]   = valid ? r : gen_trail[ChanRed][0];
      held[ChanGreen] = valid ? g : gen_trail[ChanGreen][0];
      held[ChanBlue]  = valid ? b : gen_trail[ChanBlue][0];
      for (ch = 0; ch < NumChannels; ch++) begin
         for (k = TrailDepth - 1; k > 0; k--) gen_trail[ch][k] = gen_trail[ch][k-1];
         gen_trail[ch][0] = held[ch];
      end
   endtask

   // Pick a channel sample: fully random, straddling the threshold against
   // the sample it will be compared with, a rail value, or no change at all.
   function automatic logic [SampleWidth-1:0] pick_sample(input int ch);
      int base, off, v;
      base = int'(gen_trail[ch][TrailDepth-1]);
      off  = int'(gen_thr) + int'($urandom_range(2)) - 1;
      case ($urandom_range(9))
         0, 1, 2, 3: v = int'($urandom_range(65535));
         4, 5, 6, 7: v = $urandom_range(1) ? base + off : base - off;
         8:          v = $urandom_range(1) ? 65535 : 0;
         default:    v = base;
      endcase
      if (v > 65535) v = base - off;
      if (v < 0) v = base + off;
      if (v < 0 || v > 65535) v = int'($urandom_range(65535));
      return SampleWidth'(v);
   endfunction

   task automatic add_burst(input int len);
      int n;
      for (n = 0; n < len; n++) begin
         if ($urandom_range(9) < 8)
            add_word(1'b1, pick_sample(ChanRed), pick_sample(ChanGreen), pick_sample(ChanBlue));
         else
            add_word(1'b0, SampleWidth'($urandom), SampleWidth'($urandom),
                     SampleWidth'($urandom));
      end
   endtask

   // Hold the color steady long enough for the score to fall to zero; the
   // drop clears the change count, so no burst can finish the block early.
   task automatic add_settle();
      int n;
      for (n = 0; n < HistoryDepth + 1; n++) begin
         if ($urandom_range(1))
            add_word(1'b0, SampleWidth'($urandom), SampleWidth'($urandom),
                     SampleWidth'($urandom));
         else
            add_word(1'b1, gen_trail[ChanRed][0], gen_trail[ChanGreen][0],
                     gen_trail[ChanBlue][0]);
      end
   endtask

   // Load a full register set (junk above each field) while idle.
   task automatic load_settings(input logic [SampleWidth-1:0] thr,
                                input logic [ConfWidth-1:0] lim,
                                input logic [WeightWidth-1:0] rw, gw, bw,
                                input logic [CountWidth-1:0] fin);
      drain();
      write_csr(RegThreshold, {16'($urandom), thr});
      write_csr(RegConfLimit, {26'($urandom), lim});
      write_csr(RegRedWeight, {28'($urandom), rw});
      write_csr(RegGrnWeight, {28'($urandom), gw});
      write_csr(RegBluWeight, {28'($urandom), bw});
      write_csr(RegFinish, {24'($urandom), fin});
      gen_thr = thr;
      settings_used++;
   endtask

   task automatic add_phase_words(input int words);
      int added, len;
      added = 0;
      while (added < words) begin
         len = $urandom_range(1, 40);
         add_burst(len);
         add_settle();
         added += len + HistoryDepth + 1;
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int phase;
      logic [SampleWidth-1:0] thr;
      clear_detector();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset settings: warm-up with an invalid
      // word, rail values, a full three-channel change, a score drop, a
      // difference one above and exactly at the threshold, reused samples.
      add_word(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_word(1'b0, 16'h0000, 16'h0000, 16'h0000);
      add_word(1'b1, 16'h0000, 16'h0000, 16'h0000);
      add_word(1'b1, 16'h0000, 16'h0000, 16'h0000);
      add_word(1'b1, 16'h0000, 16'h0000, 16'h0000);
      add_word(1'b1, 16'h0201, 16'h0200, 16'h0000);
      add_word(1'b1, 16'h0000, 16'h0000, 16'h0000);
      add_word(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
      add_word(1'b0, 16'h1234, 16'hABCD, 16'h5A5A);
      add_word(1'b1, 16'h0000, 16'hFFFF, 16'h0000);
      add_word(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_word(1'b1, 16'h0000, 16'h0000, 16'h0000);
      add_word(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_word(1'b1, 16'h0000, 16'h0000, 16'h0000);
      add_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_settle();

      // Random phases, each under its own register set. Finish counts stay
      // above the longest burst so the block keeps running until the end.
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: load_settings(16'd0, 6'd0, 4'd15, 4'd15, 4'd15, 8'd255);
            1: load_settings(16'hFFFF, 6'd63, 4'd0, 4'd0, 4'd0, 8'd255);
            2: load_settings(16'd512, 6'd2, 4'd1, 4'd1, 4'd1, 8'd128);
            3: load_settings(16'd300, 6'd1, 4'd8, 4'd4, 4'd2, 8'd64);
            default: begin
               thr = $urandom_range(1) ? SampleWidth'($urandom_range(3000))
                                       : SampleWidth'($urandom);
               load_settings(thr, ConfWidth'($urandom_range(45)),
                             WeightWidth'($urandom), WeightWidth'($urandom),
                             WeightWidth'($urandom), CountWidth'($urandom_range(64, 255)));
            end
         endcase
         add_phase_words(223);
      end

      // Closing stretch, no idling: a finish count of zero ends the run on the
      // first detected change; later words must leave the state frozen.
      load_settings(16'd1000, 6'd0, 4'd1, 4'd2, 4'd4, 8'd0);
      steady_tail = 1'b1;
      add_settle();
      add_word(1'b1, gen_trail[ChanRed][TrailDepth-1] ^ 16'h8000,
               gen_trail[ChanGreen][TrailDepth-1] ^ 16'h8000,
               gen_trail[ChanBlue][TrailDepth-1] ^ 16'h8000);
      add_burst(20);
      drain();

      $display("Covered %0d sensor words across %0d register sets plus the reset set,",
               words_taken, settings_used);
      $display("ending in the finished state; %0d results checked, %0d mismatches.",
               results_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASS rgb_color_change_detector_unit");
      end else begin
         $display("FAIL rgb_color_change_detector_unit");
      end
      $finish;
   end

endmodule

### filelist.f
sv/rccd_pkg.sv
sv/rccd_csr.sv
sv/rccd_channel.sv
sv/rccd_core.sv
sv/rgb_color_change_detector_unit.sv
tb/tb.sv
